[hdl/pip_pkg.sv]
package pip_pkg;

  // Fixed widths of the stream fields
  localparam int FIELD_W     = 32;
  localparam int IN_TDATA_W  = 4 * FIELD_W;
  localparam int OUT_TDATA_W = 8;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIFO_DEPTH_LOG2 = 2;

  // Field positions in s_tdata, in units of FIELD_W
  localparam int QX_SLOT = 0;
  localparam int QY_SLOT = 1;
  localparam int VX_SLOT = 2;
  localparam int VY_SLOT = 3;

  // Per-edge outcome of the bounds checks done in the front end
  typedef struct packed {
    logic hit_pre;   // y in (miny, maxy], x <= maxx, edge not horizontal
    logic vertical;  // p1.x == p2.x
    logic dy_pos;    // p2.y > p1.y
  } edge_flags_t;

  // Control part of one queue entry
  typedef struct packed {
    edge_flags_t ea;    // edge from previous vertex to current one
    edge_flags_t eb;    // closing edge from current vertex to first one
    logic        last;
  } item_ctl_t;

endpackage

[hdl/pip_front.sv]
module pip_front
  import pip_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           s_tvalid,
  output logic                                           s_tready,
  input  logic [IN_TDATA_W-1:0]                          s_tdata,
  input  logic                                           s_tlast,
  input  logic                                           q_full,
  output logic                                           push,
  output logic [$bits(item_ctl_t)+8*(COORD_WIDTH+1)-1:0] push_data
);

  localparam int W = COORD_WIDTH;
  localparam int D = COORD_WIDTH + 1;

  logic signed [W-1:0] qx, qy, vx, vy;
  logic signed [W-1:0] prev_vx, prev_vy, start_vx, start_vy;
  logic signed [W-1:0] first_x, first_y;
  logic                awaiting_start;
  logic                accept;
  edge_flags_t         fa, fb;
  item_ctl_t           ctl;

  function automatic edge_flags_t edge_check(
    input logic signed [W-1:0] x,
    input logic signed [W-1:0] y,
    input logic signed [W-1:0] p1x,
    input logic signed [W-1:0] p1y,
    input logic signed [W-1:0] p2x,
    input logic signed [W-1:0] p2y
  );
    edge_flags_t         f;
    logic signed [W-1:0] maxx, miny, maxy;
    maxx       = (p1x >= p2x) ? p1x : p2x;
    miny       = (p1y <= p2y) ? p1y : p2y;
    maxy       = (p1y >= p2y) ? p1y : p2y;
    f.hit_pre  = (y > miny) && (y <= maxy) && (x <= maxx) && (p1y != p2y);
    f.vertical = (p1x == p2x);
    f.dy_pos   = (p2y > p1y);
    return f;
  endfunction

  // Exact difference, one bit wider than the coordinates
  function automatic logic [D-1:0] sdiff(
    input logic signed [W-1:0] p,
    input logic signed [W-1:0] q
  );
    return {p[W-1], p} - {q[W-1], q};
  endfunction

  assign qx = $signed(s_tdata[QX_SLOT*FIELD_W +: W]);
  assign qy = $signed(s_tdata[QY_SLOT*FIELD_W +: W]);
  assign vx = $signed(s_tdata[VX_SLOT*FIELD_W +: W]);
  assign vy = $signed(s_tdata[VY_SLOT*FIELD_W +: W]);

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept;

  // On a first vertex the closing edge degenerates to a point
  assign first_x = awaiting_start ? vx : start_vx;
  assign first_y = awaiting_start ? vy : start_vy;

  always_comb begin
    fa          = edge_check(qx, qy, prev_vx, prev_vy, vx, vy);
    fa.hit_pre  = fa.hit_pre && !awaiting_start;
    fb          = edge_check(qx, qy, vx, vy, first_x, first_y);
    fb.hit_pre  = fb.hit_pre && s_tlast;
    ctl.ea      = fa;
    ctl.eb      = fb;
    ctl.last    = s_tlast;
  end

  // Entry layout, high to low: ctl, edge A {a, b, dx, dy}, edge B {a, b, dx, dy}
  assign push_data = {ctl,
                      sdiff(qx, prev_vx), sdiff(qy, prev_vy),
                      sdiff(vx, prev_vx), sdiff(vy, prev_vy),
                      sdiff(qx, vx),      sdiff(qy, vy),
                      sdiff(first_x, vx), sdiff(first_y, vy)};

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_start <= 1'b1;
    end else if (accept) begin
      awaiting_start <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_vx <= vx;
      prev_vy <= vy;
      if (awaiting_start) begin
        start_vx <= vx;
        start_vy <= vy;
      end
    end
  end

endmodule

[hdl/pip_fifo.sv]
module pip_fifo
  import pip_pkg::*;
#(
  parameter int WIDTH      = 8,
  parameter int DEPTH_LOG2 = FIFO_DEPTH_LOG2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]      entries [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr, rd_ptr;
  logic [DEPTH_LOG2:0]   count;

  assign full     = (count == (DEPTH_LOG2+1)'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/pip_back.sv]
module pip_back
  import pip_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           q_valid,
  input  logic [$bits(item_ctl_t)+8*(COORD_WIDTH+1)-1:0] q_data,
  output logic                                           pop,
  output logic                                           m_tvalid,
  input  logic                                           m_tready,
  output logic [OUT_TDATA_W-1:0]                         m_tdata
);

  localparam int D   = COORD_WIDTH + 1;
  localparam int P_W = 2 * D;

  item_ctl_t           q_ctl, ctl1;
  logic signed [D-1:0] a_a, b_a, dx_a, dy_a, a_b, b_b, dx_b, dy_b;
  logic signed [P_W-1:0] pa_a, pb_a, pa_b, pb_b;
  logic                v1, out_free, s1_go, load1;
  logic                le_a, le_b, cross_a, cross_b, par_new;
  logic                odd_crossings;
  logic                out_bit;

  assign {q_ctl, a_a, b_a, dx_a, dy_a, a_b, b_b, dx_b, dy_b} = q_data;

  assign out_free = !m_tvalid || m_tready;
  assign s1_go    = v1 && (!ctl1.last || out_free);
  assign load1    = !v1 || s1_go;
  assign pop      = q_valid && load1;

  // Stage 1: cross products a*dy and b*dx for both edges
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (load1) begin
      v1 <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ctl1 <= q_ctl;
      pa_a <= P_W'(a_a) * P_W'(dy_a);
      pb_a <= P_W'(b_a) * P_W'(dx_a);
      pa_b <= P_W'(a_b) * P_W'(dy_b);
      pb_b <= P_W'(b_b) * P_W'(dx_b);
    end
  end

  // Stage 2: x <= crossing x, sign of dy decides the direction of the compare
  assign le_a    = ctl1.ea.dy_pos ? (pa_a <= pb_a) : (pb_a <= pa_a);
  assign le_b    = ctl1.eb.dy_pos ? (pa_b <= pb_b) : (pb_b <= pa_b);
  assign cross_a = ctl1.ea.hit_pre && (ctl1.ea.vertical || le_a);
  assign cross_b = ctl1.eb.hit_pre && (ctl1.eb.vertical || le_b);
  assign par_new = odd_crossings ^ cross_a ^ cross_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      odd_crossings <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (s1_go) begin
        odd_crossings <= ctl1.last ? 1'b0 : par_new;
      end
      if (s1_go && ctl1.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && ctl1.last) begin
      out_bit <= par_new;
    end
  end

  assign m_tdata = {(OUT_TDATA_W-1)'(0), out_bit};

endmodule

[hdl/point_in_polygon_test_unit.sv]
// Crossing-number point-in-polygon test, one vertex per transaction.
// Throughput: one vertex per cycle while the queue is not full; a 4-entry
//   queue separates the edge bounds checks from the multiply/compare pipeline.
// A last vertex's result passes through the queue, the stage-1 product
//   registers and the output register before m_tvalid rises.
// Reset (rst, synchronous): queue emptied, parity cleared, next vertex is first.
module point_in_polygon_test_unit
  import pip_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // query_x, query_y, vertex_x, vertex_y
  input  logic                   s_tlast,   // last_vertex
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // inside_res, zero pad
);

  localparam int ENTRY_W = $bits(item_ctl_t) + 8 * (COORD_WIDTH + 1);

  logic               push, pop, q_full, q_valid;
  logic [ENTRY_W-1:0] push_data, q_data;

  pip_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  pip_fifo #(
    .WIDTH     (ENTRY_W),
    .DEPTH_LOG2(FIFO_DEPTH_LOG2)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_data (q_data)
  );

  pip_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

[hdl/pip_checker.sv]
module pip_assert_checker
  import pip_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:1] == '0)
    else $error("nonzero pad bits in result");

  a_rst_out: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_rst_ready: assert property (@(posedge clk)
    $past(rst) |-> s_tready)
    else $error("input not ready right after reset");

endmodule

bind point_in_polygon_test_unit pip_assert_checker u_pip_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
